FILE: sv/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the transition row checker.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The condition must hold in the same cycle as the trigger.
`define ASSERT_SAME(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error("assertion failed in transition row checker");

// The condition must hold in the cycle after the trigger.
`define ASSERT_NEXT(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error("assertion failed in transition row checker");

`endif

FILE: sv/mgtr_pkg.sv
// ----------------------------------------------------------------------------
// mgtr_pkg
// Types, widths and constants of the Moran transition row block.
// ----------------------------------------------------------------------------
package mgtr_pkg;

   localparam int POP_SIZE_DEF = 8;

   // Field and register widths.
   localparam int MASK_W     = 8;
   localparam int PROB_W     = 17;
   localparam int ADJ_W      = 64;
   localparam int ADJ_IDX_W  = 6;
   localparam int FIT_W      = 16;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 64;

   // Datapath widths, sized for up to eight vertices.
   localparam int CNT_MAX_W  = 4;
   localparam int S_W        = 20;
   localparam int PROD_W     = FIT_W + CNT_MAX_W;
   localparam int NUM_W      = 36;
   localparam int DEN_W      = 24;
   localparam int SUM_W      = NUM_W + 4;

   // Divider retires this many quotient bits per cycle.
   localparam int DIV_BITS   = 2;
   localparam int DIV_STEPS  = NUM_W / DIV_BITS;
   localparam int DSTEP_W    = $clog2(DIV_STEPS);

   // Fixed-point shifts.
   localparam int Q12_SHIFT    = 12;
   localparam int Q16_SHIFT    = 16;
   localparam int DB_MUT_SHIFT = 28;

   localparam logic [FIT_W-1:0] ONE_Q12 = FIT_W'(4096);
   localparam logic [SUM_W-1:0] ONE_Q16 = SUM_W'(65536);

   // Register indexes of the configuration port.
   localparam logic [CSR_IDX_W-1:0] CSR_ADJACENCY = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_FITNESS   = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_RULE      = 2'd2;

   localparam logic [FIT_W-1:0] FITNESS_RESET = FIT_W'(4096);

   // Update rule codes.
   localparam logic RULE_BIRTH_DEATH = 1'b0;
   localparam logic RULE_DEATH_BIRTH = 1'b1;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_MUL,
      ST_DEN,
      ST_DIV,
      ST_OUT,
      ST_SELF
   } st_type;

   // Status from the datapath to the sequencer.
   typedef struct packed {
      logic req_valid;
      logic k_last;
      logic j_last;
      logic div_done;
      logic slot_free;
   } sts_type;

   // Commands from the sequencer to the datapath.
   typedef struct packed {
      logic idle;
      logic start_item;
      logic scan_step;
      logic mul_step;
      logic div_start;
      logic emit_flip;
      logic emit_self;
   } cmd_type;

   // Truncated 65536 / d for an outdegree d; zero degree gives zero.
   function automatic logic [PROB_W-1:0] recip_q16(input logic [CNT_MAX_W-1:0] d);
      logic [PROB_W-1:0] r;
      case (d)
         4'd1:    r = 17'd65536;
         4'd2:    r = 17'd32768;
         4'd3:    r = 17'd21845;
         4'd4:    r = 17'd16384;
         4'd5:    r = 17'd13107;
         4'd6:    r = 17'd10922;
         4'd7:    r = 17'd9362;
         4'd8:    r = 17'd8192;
         default: r = '0;
      endcase
      return r;
   endfunction

endpackage

FILE: sv/moran_graph_transition_row_top.sv
// ----------------------------------------------------------------------------
// moran_graph_transition_row_top
// Moran-process transition row on a directed graph: one state mask in,
// one flip probability per vertex and then the self-loop out.
// ----------------------------------------------------------------------------
//  channel   direction  handshake             payload
//  req       in         req_valid/req_stall   req_state_mask
//  rsp       out        rsp_valid/rsp_stall   rsp_probability, rsp_from_state,
//                                             rsp_to_state, rsp_last
//  csr       in         csr_wr_en             csr_index, csr_wdata
//
// The shared divider sets most of the time that one state takes when the
// output does not stall. Each vertex takes a neighbor scan over the source
// rows, the fitness products, the divider operands, the divide and the emit.
// req_stall is high from the transfer of a state until its self-loop result
// has been loaded into the output register. A stalled result holds the
// sequencer in its emit state until the output register is free.
// Reset is synchronous and restores the configuration register defaults.
// ----------------------------------------------------------------------------
module moran_graph_transition_row_top #(
   parameter int POP_SIZE = mgtr_pkg::POP_SIZE_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_stall,
   input  logic [mgtr_pkg::MASK_W-1:0]      req_state_mask,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output logic [mgtr_pkg::PROB_W-1:0]      rsp_probability,
   output logic [mgtr_pkg::MASK_W-1:0]      rsp_from_state,
   output logic [mgtr_pkg::MASK_W-1:0]      rsp_to_state,
   output logic                             rsp_last,
   input  logic                             csr_wr_en,
   input  logic [mgtr_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [mgtr_pkg::CSR_DATA_W-1:0]  csr_wdata
);
   import mgtr_pkg::*;

   localparam int KW    = $clog2(POP_SIZE);
   localparam int CNT_W = $clog2(POP_SIZE + 1);

   // Configuration registers.
   logic [ADJ_W-1:0]   adj_ff;
   logic [FIT_W-1:0]   fit_ff;
   logic               rule_ff;

   // Per-state and per-vertex working registers.
   logic [MASK_W-1:0]  mask_ff;
   logic [KW-1:0]      j_ff, j_in;
   logic [KW-1:0]      k_ff, k_in;
   logic [CNT_W-1:0]   m_ff, m_in;
   logic [CNT_W-1:0]   n_ff, n_in;
   logic [CNT_W-1:0]   c_ff, c_in;
   logic [S_W-1:0]     s_ff, s_in;
   logic [PROD_W-1:0]  prod_ff;
   logic [NUM_W-1:0]   bd_num_ff;
   logic [SUM_W-1:0]   sum_ff, sum_in;

   // Output register.
   logic               rsp_valid_ff, rsp_valid_in;
   logic [PROB_W-1:0]  rsp_prob_ff, rsp_prob_in;
   logic [MASK_W-1:0]  rsp_from_ff, rsp_from_in;
   logic [MASK_W-1:0]  rsp_to_ff, rsp_to_in;
   logic               rsp_last_ff, rsp_last_in;

   sts_type            sts;
   cmd_type            cmd;

   logic               jm;
   logic               k_last, j_last;
   logic               slot_free;
   logic [NUM_W-1:0]   div_num;
   logic [DEN_W-1:0]   div_den;
   logic               div_done;
   logic [NUM_W-1:0]   div_quo;
   logic [CNT_W-1:0]   deg;
   logic               edge_kj;
   logic [PROB_W-1:0]  self_prob;

   // ---------------------------------------------------------------- config
   always_ff @(posedge clock) begin
      if (reset) begin
         adj_ff  <= '0;
         fit_ff  <= FITNESS_RESET;
         rule_ff <= RULE_BIRTH_DEATH;
      end else if (csr_wr_en) begin
         case (csr_index)
            CSR_ADJACENCY: adj_ff  <= csr_wdata;
            CSR_FITNESS:   fit_ff  <= csr_wdata[FIT_W-1:0];
            CSR_RULE:      rule_ff <= csr_wdata[0];
            default:       adj_ff  <= adj_ff;
         endcase
      end
   end

   // ---------------------------------------------------------------- status
   assign jm        = mask_ff[j_ff];
   assign k_last    = (k_ff == KW'(POP_SIZE - 1));
   assign j_last    = (j_ff == KW'(POP_SIZE - 1));
   assign slot_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      sts           = '0;
      sts.req_valid = req_valid;
      sts.k_last    = k_last;
      sts.j_last    = j_last;
      sts.div_done  = div_done;
      sts.slot_free = slot_free;
   end

   assign req_stall = !cmd.idle;

   mgtr_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .sts   (sts),
      .cmd   (cmd)
   );

   // ---------------------------------------------------------- neighbor scan
   // Outdegree of the source row k and the edge from k to the current vertex.
   always_comb begin
      logic [ADJ_IDX_W-1:0] base;
      base = ADJ_IDX_W'(k_ff) * ADJ_IDX_W'(POP_SIZE);
      deg  = '0;
      for (int t = 0; t < POP_SIZE; t++) begin
         deg = deg + CNT_W'(adj_ff[base + ADJ_IDX_W'(t)]);
      end
      edge_kj = adj_ff[base + ADJ_IDX_W'(j_ff)];
   end

   always_comb begin
      logic km;
      km   = mask_ff[k_ff];
      k_in = k_ff;
      m_in = m_ff;
      n_in = n_ff;
      c_in = c_ff;
      s_in = s_ff;
      if (cmd.start_item || cmd.emit_flip) begin
         k_in = '0;
         m_in = '0;
         n_in = '0;
         c_in = '0;
         s_in = '0;
      end else if (cmd.scan_step) begin
         k_in = k_last ? '0 : k_ff + KW'(1);
         if (km) m_in = m_ff + CNT_W'(1);
         if (edge_kj) begin
            n_in = n_ff + CNT_W'(1);
            if (km) c_in = c_ff + CNT_W'(1);
            if (km != jm) s_in = s_ff + S_W'(recip_q16(CNT_MAX_W'(deg)));
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         k_ff <= '0;
         j_ff <= '0;
      end else begin
         k_ff <= k_in;
         j_ff <= j_in;
      end
   end

   always_ff @(posedge clock) begin
      m_ff <= m_in;
      n_ff <= n_in;
      c_ff <= c_in;
      s_ff <= s_in;
      if (cmd.start_item) mask_ff <= req_state_mask;
   end

   // ------------------------------------------------------------------ setup
   // First cycle: the fitness products. Second cycle: the divider operands.
   always_ff @(posedge clock) begin
      if (cmd.mul_step) begin
         prod_ff   <= PROD_W'(fit_ff) * PROD_W'(rule_ff ? c_ff : m_ff);
         bd_num_ff <= NUM_W'(s_ff) * NUM_W'(jm ? ONE_Q12 : fit_ff);
      end
   end

   always_comb begin
      logic [CNT_W-1:0] nmc;
      logic [CNT_W-1:0] wm;
      logic [DEN_W-1:0] db_base;
      logic [DEN_W-1:0] db_den;
      logic [DEN_W-1:0] bd_den;
      logic [NUM_W-1:0] db_num;
      nmc     = n_ff - c_ff;
      wm      = CNT_W'(POP_SIZE) - m_ff;
      bd_den  = DEN_W'(prod_ff) + (DEN_W'(wm) << Q12_SHIFT);
      db_base = DEN_W'(prod_ff) + (DEN_W'(nmc) << Q12_SHIFT);
      db_den  = DEN_W'(db_base * DEN_W'(POP_SIZE));
      db_num  = jm ? (NUM_W'(nmc) << DB_MUT_SHIFT) : (NUM_W'(prod_ff) << Q16_SHIFT);
      div_num = (rule_ff == RULE_DEATH_BIRTH) ? db_num : bd_num_ff;
      div_den = (rule_ff == RULE_DEATH_BIRTH) ? db_den : bd_den;
   end

   mgtr_div u_div (
      .clock (clock),
      .reset (reset),
      .start (cmd.div_start),
      .num   (div_num),
      .den   (div_den),
      .done  (div_done),
      .quo   (div_quo)
   );

   // ---------------------------------------------------------------- results
   assign self_prob = (sum_ff >= ONE_Q16) ? '0 : PROB_W'(ONE_Q16 - sum_ff);

   always_comb begin
      j_in         = j_ff;
      sum_in       = sum_ff;
      rsp_prob_in  = rsp_prob_ff;
      rsp_from_in  = rsp_from_ff;
      rsp_to_in    = rsp_to_ff;
      rsp_last_in  = rsp_last_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      if (cmd.start_item) begin
         j_in   = '0;
         sum_in = '0;
      end
      if (cmd.emit_flip) begin
         j_in         = j_last ? '0 : j_ff + KW'(1);
         sum_in       = sum_ff + SUM_W'(div_quo);
         rsp_prob_in  = div_quo[PROB_W-1:0];
         rsp_from_in  = mask_ff;
         rsp_to_in    = mask_ff ^ (MASK_W'(1) << j_ff);
         rsp_last_in  = 1'b0;
         rsp_valid_in = 1'b1;
      end else if (cmd.emit_self) begin
         rsp_prob_in  = self_prob;
         rsp_from_in  = mask_ff;
         rsp_to_in    = mask_ff;
         rsp_last_in  = 1'b1;
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      sum_ff      <= sum_in;
      rsp_prob_ff <= rsp_prob_in;
      rsp_from_ff <= rsp_from_in;
      rsp_to_ff   <= rsp_to_in;
      rsp_last_ff <= rsp_last_in;
   end

   // The source state is registered with the result, since a new state may be
   // taken while the self-loop result still waits.
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_probability = rsp_prob_ff;
   assign rsp_from_state  = rsp_from_ff;
   assign rsp_to_state    = rsp_to_ff;
   assign rsp_last        = rsp_last_ff;

endmodule

FILE: sv/mgtr_div.sv
// ----------------------------------------------------------------------------
// mgtr_div
// Shared restoring divider, two quotient bits per cycle, zero divisor gives 0.
// ----------------------------------------------------------------------------
module mgtr_div (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  logic [mgtr_pkg::NUM_W-1:0]  num,
   input  logic [mgtr_pkg::DEN_W-1:0]  den,
   output logic                        done,
   output logic [mgtr_pkg::NUM_W-1:0]  quo
);
   import mgtr_pkg::*;

   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [DSTEP_W-1:0]   cnt_ff, cnt_in;
   logic [DEN_W-1:0]     rem_ff, rem_in;
   logic [NUM_W-1:0]     sh_ff, sh_in;
   logic [DEN_W-1:0]     den_ff, den_in;
   logic                 dz_ff, dz_in;
   logic                 last_step;

   assign last_step = (cnt_ff == DSTEP_W'(DIV_STEPS - 1));

   // The shift register holds the dividend bits still to be brought down in
   // its upper part and the quotient bits already formed in its lower part.
   always_comb begin
      logic [DEN_W:0]   t;
      logic [DEN_W-1:0] r;
      logic [NUM_W-1:0] s;
      r = rem_ff;
      s = sh_ff;
      for (int i = 0; i < DIV_BITS; i++) begin
         t = {r, s[NUM_W-1]};
         s = {s[NUM_W-2:0], 1'b0};
         if (t >= {1'b0, den_ff}) begin
            r    = DEN_W'(t - {1'b0, den_ff});
            s[0] = 1'b1;
         end else begin
            r = t[DEN_W-1:0];
         end
      end
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      sh_in   = sh_ff;
      den_in  = den_ff;
      dz_in   = dz_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         rem_in  = '0;
         sh_in   = num;
         den_in  = den;
         dz_in   = (den == '0);
      end else if (busy_ff) begin
         rem_in = r;
         sh_in  = s;
         cnt_in = cnt_ff + DSTEP_W'(1);
         if (last_step) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      sh_ff  <= sh_in;
      den_ff <= den_in;
      dz_ff  <= dz_in;
   end

   assign done = done_ff;
   assign quo  = dz_ff ? '0 : sh_ff;

endmodule

FILE: sv/mgtr_ctrl.sv
// ----------------------------------------------------------------------------
// mgtr_ctrl
// Sequencer: neighbor scan, setup, divide and emit for each vertex in turn, then the self-loop emit.
// ----------------------------------------------------------------------------
module mgtr_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  mgtr_pkg::sts_type  sts,
   output mgtr_pkg::cmd_type  cmd
);
   import mgtr_pkg::*;

   st_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: if (sts.req_valid) state_in = ST_SCAN;
         ST_SCAN: if (sts.k_last) state_in = ST_MUL;
         ST_MUL:  state_in = ST_DEN;
         ST_DEN:  state_in = ST_DIV;
         ST_DIV:  if (sts.div_done) state_in = ST_OUT;
         ST_OUT: begin
            if (sts.slot_free) state_in = sts.j_last ? ST_SELF : ST_SCAN;
         end
         ST_SELF: if (sts.slot_free) state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd = '0;
      case (state_ff)
         ST_IDLE: begin
            cmd.idle       = 1'b1;
            cmd.start_item = sts.req_valid;
         end
         ST_SCAN: cmd.scan_step = 1'b1;
         ST_MUL:  cmd.mul_step  = 1'b1;
         ST_DEN:  cmd.div_start = 1'b1;
         ST_DIV:  cmd = '0;
         ST_OUT:  cmd.emit_flip = sts.slot_free;
         ST_SELF: cmd.emit_self = sts.slot_free;
         default: cmd = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

FILE: sv/mgtr_checker.sv
// ----------------------------------------------------------------------------
// mgtr_checker
// Port-level checks of the transition row block, bound to its top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module mgtr_checker (
   input logic                             clock,
   input logic                             reset,
   input logic                             req_valid,
   input logic                             req_stall,
   input logic [mgtr_pkg::MASK_W-1:0]      req_state_mask,
   input logic                             rsp_valid,
   input logic                             rsp_stall,
   input logic [mgtr_pkg::PROB_W-1:0]      rsp_probability,
   input logic [mgtr_pkg::MASK_W-1:0]      rsp_from_state,
   input logic [mgtr_pkg::MASK_W-1:0]      rsp_to_state,
   input logic                             rsp_last,
   input logic                             csr_wr_en,
   input logic [mgtr_pkg::CSR_IDX_W-1:0]   csr_index,
   input logic [mgtr_pkg::CSR_DATA_W-1:0]  csr_wdata
);
   import mgtr_pkg::*;

   logic req_xfer;
   logic rsp_hold;
   logic unused_ok;

   assign req_xfer  = req_valid && !req_stall;
   assign rsp_hold  = rsp_valid && rsp_stall;
   assign unused_ok = csr_wr_en || (csr_index != '0) || (csr_wdata != '0) ||
                      (req_state_mask != '0);

   // A held result stays offered with the same probability, target state and last flag.
   `ASSERT_NEXT(a_rsp_valid_holds, clock, reset, rsp_hold, rsp_valid)
   `ASSERT_NEXT(a_rsp_payload_holds, clock, reset, rsp_hold, $stable(rsp_probability) && $stable(rsp_to_state) && $stable(rsp_last))

   // A flip result differs from its source state in exactly one vertex.
   `ASSERT_SAME(a_flip_one_bit, clock, reset, rsp_valid && !rsp_last, $countones(rsp_from_state ^ rsp_to_state) == 1)

   // The self-loop keeps the state and never exceeds one.
   `ASSERT_SAME(a_self_loop, clock, reset, rsp_valid && rsp_last, (rsp_to_state == rsp_from_state) && (rsp_probability <= 17'd65536))

   // After taking a state the block is busy with it.
   `ASSERT_NEXT(a_busy_after_req, clock, reset, req_xfer, req_stall || unused_ok)

endmodule

bind moran_graph_transition_row_top mgtr_checker u_mgtr_checker (.*);
